// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the reorder buffer RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rrb_pkg.sv -----
// Shared types and constants for the resequencing reorder buffer.
// No dependencies; compile first after the assertion macro header.
package rrb_pkg;

   localparam int INDEX_W          = 16;
   localparam int PAYLOAD_W        = 64;
   localparam int DEPTH_DEF        = 16;
   localparam int SEQ_BITS_DEF     = 16;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam logic STATUS_RELEASED = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   typedef struct packed {
      logic valid;
      logic status;
      logic last;
   } emit_type;

   typedef struct packed {
      logic en;
      logic valid;
   } mem_wr_type;

endpackage

// ----- rtl/rrb_if.sv -----
// Valid/ready channel interfaces for request and response traffic.
// Depends on rrb_pkg for the field widths.
interface rrb_req_if;
   logic                          valid;
   logic                          ready;
   logic [rrb_pkg::INDEX_W-1:0]   seq_index;
   logic [rrb_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, output seq_index, output payload, input ready);
   modport sink   (input valid, input seq_index, input payload, output ready);
endinterface

interface rrb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rrb_pkg::INDEX_W-1:0]   out_index;
   logic [rrb_pkg::PAYLOAD_W-1:0] out_payload;
   logic                          status;
   logic                          last;

   modport source (output valid, output out_index, output out_payload, output status,
                   output last, input ready);
   modport sink   (input valid, input out_index, input out_payload, input status,
                   input last, output ready);
endinterface

// ----- rtl/rrb_slot_mem.sv -----
// Slot memory: one synchronous RAM holding a valid bit and a payload per slot.
// Depends on rrb_pkg; read data is registered, with write-to-read forwarding.
module rrb_slot_mem #(
   parameter int DEPTH        = rrb_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BITS = rrb_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  rrb_pkg::mem_wr_type        wr,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [PAYLOAD_BITS-1:0]    wr_payload,
   output logic                       rd_valid,
   output logic [PAYLOAD_BITS-1:0]    rd_payload
);
   import rrb_pkg::*;

   localparam int WORD_W = PAYLOAD_BITS + 1;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] fwd_word_ff;
   logic              fwd_ff;
   logic              fwd_in;
   logic [WORD_W-1:0] wr_word;

   assign wr_word = {wr.valid, wr_payload};
   assign fwd_in  = wr.en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_word_ff  <= mem[rd_addr];
      fwd_word_ff <= wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   // Take the word written on the same edge the read was issued.
   assign {rd_valid, rd_payload} = fwd_ff ? fwd_word_ff : rd_word_ff;

endmodule

// ----- rtl/rrb_ctrl.sv -----
// Sequencer of the reorder buffer: expected number, slot mapping, drain loop.
// Depends on rrb_pkg and assert_macros.svh; drives rrb_slot_mem.
module rrb_ctrl #(
   parameter int DEPTH        = rrb_pkg::DEPTH_DEF,
   parameter int SEQ_BITS     = rrb_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = rrb_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [SEQ_BITS-1:0]        in_index,
   input  logic [PAYLOAD_BITS-1:0]    in_payload,
   input  logic                       out_free,
   output rrb_pkg::emit_type          emit,
   output logic [SEQ_BITS-1:0]        emit_index,
   output logic [PAYLOAD_BITS-1:0]    emit_payload,
   output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
   output rrb_pkg::mem_wr_type        mem_wr,
   output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
   output logic [PAYLOAD_BITS-1:0]    mem_wr_payload,
   input  logic                       mem_rd_valid,
   input  logic [PAYLOAD_BITS-1:0]    mem_rd_payload
);
   import rrb_pkg::*;

   `include "assert_macros.svh"

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = $clog2(3 * DEPTH);
   localparam int CMP_W  = 33;
   // Slot offset to add when the forward distance crosses the number wrap.
   localparam longint unsigned SEQ_SPAN = 64'd1 << SEQ_BITS;
   localparam longint unsigned WRAP_REM = SEQ_SPAN % DEPTH;
   localparam longint unsigned WRAP_ADJ = (DEPTH - WRAP_REM) % DEPTH;

   state_type                state_ff, state_in;
   logic [SEQ_BITS-1:0]      exp_ff, exp_in;
   logic [SLOT_W-1:0]        exp_slot_ff, exp_slot_in;
   logic [SLOT_W-1:0]        look_addr_ff, look_addr_in;
   logic [SLOT_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SEQ_BITS-1:0]      item_index_ff, item_index_in;
   logic [PAYLOAD_BITS-1:0]  item_payload_ff, item_payload_in;
   logic                     item_win_ff, item_win_in;

   logic [SEQ_BITS-1:0]      fwd_gap;
   logic                     in_order;
   logic                     in_win;
   logic                     in_wrap;
   logic [SUM_W-1:0]         slot_sum;
   logic [SLOT_W-1:0]        in_slot;
   logic [SLOT_W-1:0]        exp_slot_nxt;
   logic                     more;

   // Map the incoming number to its slot from the expected slot and the distance.
   always_comb begin
      fwd_gap  = in_index - exp_ff;
      in_order = (fwd_gap == '0);
      in_win   = (CMP_W'(fwd_gap) < CMP_W'(DEPTH));
      in_wrap  = (in_index < exp_ff);
      slot_sum = SUM_W'(exp_slot_ff) + SUM_W'(fwd_gap) + (in_wrap ? SUM_W'(WRAP_ADJ) : '0);
      if (slot_sum >= SUM_W'(2 * DEPTH)) begin
         in_slot = SLOT_W'(slot_sum - SUM_W'(2 * DEPTH));
      end else if (slot_sum >= SUM_W'(DEPTH)) begin
         in_slot = SLOT_W'(slot_sum - SUM_W'(DEPTH));
      end else begin
         in_slot = SLOT_W'(slot_sum);
      end
   end

   always_comb begin
      if (exp_ff == '1) begin
         exp_slot_nxt = '0;
      end else if (exp_slot_ff == SLOT_W'(DEPTH - 1)) begin
         exp_slot_nxt = '0;
      end else begin
         exp_slot_nxt = exp_slot_ff + SLOT_W'(1);
      end
   end

   assign more = mem_rd_valid && (cnt_ff != CNT_W'(DEPTH));

   always_comb begin
      state_in        = state_ff;
      exp_in          = exp_ff;
      exp_slot_in     = exp_slot_ff;
      look_addr_in    = look_addr_ff;
      clr_addr_in     = clr_addr_ff;
      cnt_in          = cnt_ff;
      item_index_in   = item_index_ff;
      item_payload_in = item_payload_ff;
      item_win_in     = item_win_ff;
      emit            = '0;
      mem_wr          = '0;
      in_ready        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            clr_addr_in = clr_addr_ff + SLOT_W'(1);
            if (clr_addr_ff == SLOT_W'(DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               item_index_in   = in_index;
               item_payload_in = in_payload;
               item_win_in     = in_win;
               if (in_order) begin
                  exp_in       = in_index + SEQ_BITS'(1);
                  exp_slot_in  = exp_slot_nxt;
                  look_addr_in = exp_slot_nxt;
                  cnt_in       = CNT_W'(1);
                  state_in     = ST_DRAIN;
               end else begin
                  look_addr_in = in_slot;
                  state_in     = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!item_win_ff || mem_rd_valid) begin
               if (out_free) begin
                  emit.valid  = 1'b1;
                  emit.status = STATUS_REJECTED;
                  emit.last   = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               mem_wr.en    = 1'b1;
               mem_wr.valid = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = STATUS_RELEASED;
               emit.last   = !more;
               if (more) begin
                  // Pull the next held item and free its slot.
                  mem_wr.en       = 1'b1;
                  item_index_in   = exp_ff;
                  item_payload_in = mem_rd_payload;
                  exp_in          = exp_ff + SEQ_BITS'(1);
                  exp_slot_in     = exp_slot_nxt;
                  look_addr_in    = exp_slot_nxt;
                  cnt_in          = cnt_ff + CNT_W'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         exp_ff      <= '0;
         exp_slot_ff <= '0;
         clr_addr_ff <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         exp_ff      <= exp_in;
         exp_slot_ff <= exp_slot_in;
         clr_addr_ff <= clr_addr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      look_addr_ff    <= look_addr_in;
      item_index_ff   <= item_index_in;
      item_payload_ff <= item_payload_in;
      item_win_ff     <= item_win_in;
   end

   assign emit_index     = item_index_ff;
   assign emit_payload   = item_payload_ff;
   assign mem_rd_addr    = look_addr_in;
   assign mem_wr_addr    = (state_ff == ST_CLEAR) ? clr_addr_ff : look_addr_ff;
   assign mem_wr_payload = item_payload_ff;

   `ASSERT_NEXT(a_last_to_idle, clock, reset, emit.valid && emit.last,
                state_ff == ST_IDLE, "final response must return the sequencer to idle")
   `ASSERT_IMPL(a_reject_last, clock, reset, emit.valid && (emit.status == STATUS_REJECTED),
                emit.last, "rejected request must produce a single final response")
   `ASSERT_NEXT(a_drain_step, clock, reset,
                (state_ff == ST_DRAIN) && emit.valid && !emit.last,
                exp_ff == ($past(exp_ff) + SEQ_BITS'(1)), "drain must advance expected number")

endmodule

// ----- rtl/resequencing_reorder_buffer_unit.sv -----
// Channel    | Dir | Handshake   | Fields
// req_chan   | in  | valid/ready | seq_index[15:0], payload[63:0]
// rsp_chan   | out | valid/ready | out_index[15:0], out_payload[63:0], status, last
//
// Requests: one is taken in ST_IDLE; an out-of-order one is judged in the next
// cycle, when the slot memory read returns, and is stored or rejected; an in-order
// one is released with the held items behind it (up to DEPTH results).
// No new request is taken until the sequencer is back in ST_IDLE.
// Reset: synchronous; afterwards a clearing pass over all DEPTH slots zeroes the
// valid bits, with req_chan.ready low throughout.
// Stalls: an undrained full response register holds a sequencer with a response
// to emit; the next request is still taken while a finished response waits.
//
// Top level of the resequencing reorder buffer. Depends on rrb_pkg, rrb_if,
// rrb_slot_mem, rrb_ctrl and assert_macros.svh.
module resequencing_reorder_buffer_unit #(
   parameter int DEPTH        = rrb_pkg::DEPTH_DEF,
   parameter int SEQ_BITS     = rrb_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = rrb_pkg::PAYLOAD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rrb_req_if.sink    req_chan,
   rrb_rsp_if.source  rsp_chan
);
   import rrb_pkg::*;

   `include "assert_macros.svh"

   localparam int SLOT_W = $clog2(DEPTH);

   emit_type                  emit;
   logic [SEQ_BITS-1:0]       emit_index;
   logic [PAYLOAD_BITS-1:0]   emit_payload;
   logic                      out_free;
   logic [SLOT_W-1:0]         mem_rd_addr;
   mem_wr_type                mem_wr;
   logic [SLOT_W-1:0]         mem_wr_addr;
   logic [PAYLOAD_BITS-1:0]   mem_wr_payload;
   logic                      mem_rd_valid;
   logic [PAYLOAD_BITS-1:0]   mem_rd_payload;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic [PAYLOAD_W-1:0]      rsp_payload_ff;
   logic                      rsp_status_ff;
   logic                      rsp_last_ff;

   // Keep only the low SEQ_BITS / PAYLOAD_BITS of each request field.
   rrb_ctrl #(
      .DEPTH        (DEPTH),
      .SEQ_BITS     (SEQ_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .in_index       (SEQ_BITS'(req_chan.seq_index)),
      .in_payload     (PAYLOAD_BITS'(req_chan.payload)),
      .out_free       (out_free),
      .emit           (emit),
      .emit_index     (emit_index),
      .emit_payload   (emit_payload),
      .mem_rd_addr    (mem_rd_addr),
      .mem_wr         (mem_wr),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_payload (mem_wr_payload),
      .mem_rd_valid   (mem_rd_valid),
      .mem_rd_payload (mem_rd_payload)
   );

   rrb_slot_mem #(
      .DEPTH        (DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_slot_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (mem_rd_addr),
      .wr         (mem_wr),
      .wr_addr    (mem_wr_addr),
      .wr_payload (mem_wr_payload),
      .rd_valid   (mem_rd_valid),
      .rd_payload (mem_rd_payload)
   );

   // Response register: load when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response fields until the next emit.
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_index_ff   <= INDEX_W'(emit_index);
         rsp_payload_ff <= PAYLOAD_W'(emit_payload);
         rsp_status_ff  <= emit.status;
         rsp_last_ff    <= emit.last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_index   = rsp_index_ff;
   assign rsp_chan.out_payload = rsp_payload_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.last        = rsp_last_ff;

   `ASSERT_IMPL(a_emit_room, clock, reset, emit.valid, out_free,
                "response emitted while the response register is still full")

endmodule
